// ===== src/wvss_pkg.sv =====
// Package for the windowed vital sign statistics block.
// Holds window sizing, field widths, register indexes and the sequencer state type.
// No dependencies.
package wvss_pkg;

    // Window geometry
    localparam int WINDOW_LEN = 60;
    localparam int ADDR_W     = $clog2(WINDOW_LEN);
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

    // Channels: heart rate, oxygen level, saturated variability
    localparam int NUM_CH    = 3;
    localparam int SAMPLE_W  = 8;
    localparam int SUM_W     = 16;
    localparam int COUNT_W   = 8;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Acceptance and saturation limits
    localparam logic [7:0]  MIN_PAYLOAD = 8'd4;
    localparam logic [15:0] SAT_LIMIT   = 16'd255;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'd255;

    // Port widths
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 80;
    localparam int FILL_OUT_W = 6;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register indexes (word index taken from paddr[2])
    localparam logic REG_SOURCE_CODE = 1'b0;
    localparam logic REG_REPORT_CODE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== src/windowed_vital_sign_stats.sv =====
// Windowed vital sign statistics: top level with window memory, scan and divider.
// Depends on wvss_pkg.
//
// Every beat on the slave side returns one result beat holding the minimum and maximum
// of the heart rate, oxygen and variability windows, the fill count and per channel a
// running average of pushed samples, whose sum and count restart from the window once
// the count saturates at 255; m_tuser flags whether the report matched the configured
// source and command codes (and carried at least four payload bytes) and so was pushed
// into the windows. The three 60-entry windows share one memory word per slot, in a
// memory with one write port and one registered read port. An item is accepted and
// written, then the filled slots are scanned through the read port, a bit-serial
// restoring divider forms the averages and the output register is loaded. Loading
// waits while the previous result is still held on the master side. The next beat is
// taken in the cycle after the output register is loaded, so a new beat can be taken
// while the previous result still waits on the master side. The windows need no
// clearing after reset, only filled slots are read.
module windowed_vital_sign_stats (
    input  logic                          aclk,
    input  logic                          aresetn,
    // source_id[7:0], command_id[15:8], payload_length[23:16], heart_rate[31:24],
    // oxygen_level[39:32], variability_ms[55:40]
    input  logic [wvss_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rate_average[7:0], rate_minimum[15:8], rate_maximum[23:16],
    // oxygen_average[31:24], oxygen_minimum[39:32], oxygen_maximum[47:40],
    // variability_average[55:48], variability_minimum[63:56],
    // variability_maximum[71:64], fill_count[77:72], zero[79:78]
    output logic [wvss_pkg::M_DATA_W-1:0] m_tdata,
    // updated[0]
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wvss_pkg::PADDR_W-1:0]  paddr,
    input  logic [wvss_pkg::PDATA_W-1:0]  pwdata,
    output logic [wvss_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import wvss_pkg::*;

    localparam int WORD_W = NUM_CH * SAMPLE_W;

    // Window memory: one slot holds all three channel samples
    logic [WORD_W-1:0] mem [WINDOW_LEN];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic              rd_en;

    // Configuration
    logic [7:0] source_code_reg, source_code_next;
    logic [7:0] report_code_reg, report_code_next;
    logic       cfg_write;

    // Sequencer and window bookkeeping
    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0]  wpos_reg, wpos_next;
    logic [FILL_W-1:0]  scan_addr_reg, scan_addr_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               upd_reg, upd_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Per-channel state
    logic [SUM_W-1:0]    sum_reg [NUM_CH];
    logic [SUM_W-1:0]    sum_next [NUM_CH];
    logic [COUNT_W-1:0]  cnt_reg [NUM_CH];
    logic [COUNT_W-1:0]  cnt_next [NUM_CH];
    logic                recomp_reg [NUM_CH];
    logic                recomp_next [NUM_CH];
    logic [SAMPLE_W-1:0] min_reg [NUM_CH];
    logic [SAMPLE_W-1:0] min_next [NUM_CH];
    logic [SAMPLE_W-1:0] max_reg [NUM_CH];
    logic [SAMPLE_W-1:0] max_next [NUM_CH];
    logic [SUM_W-1:0]    ssum_reg [NUM_CH];
    logic [SUM_W-1:0]    ssum_next [NUM_CH];
    logic [SUM_W-1:0]    dq_reg [NUM_CH];
    logic [SUM_W-1:0]    dq_next [NUM_CH];
    logic [COUNT_W-1:0]  rem_reg [NUM_CH];
    logic [COUNT_W-1:0]  rem_next [NUM_CH];

    // Divider step results
    logic [COUNT_W:0]    dtrial [NUM_CH];
    logic                dbit [NUM_CH];
    logic [COUNT_W-1:0]  drem [NUM_CH];

    // Output register
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Input field decode
    logic [7:0]  in_src, in_cmd, in_len;
    logic [15:0] in_var;
    logic [SAMPLE_W-1:0] in_sample [NUM_CH];
    logic        in_acc;
    logic        in_pass;

    assign in_src       = s_tdata[7:0];
    assign in_cmd       = s_tdata[15:8];
    assign in_len       = s_tdata[23:16];
    assign in_sample[0] = s_tdata[31:24];
    assign in_sample[1] = s_tdata[39:32];
    assign in_var       = s_tdata[55:40];
    assign in_sample[2] = (in_var > SAT_LIMIT) ? SAT_LIMIT[7:0] : in_var[7:0];
    assign in_pass      = (in_src == source_code_reg) && (in_cmd == report_code_reg) &&
                          (in_len >= MIN_PAYLOAD);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tvalid = m_tvalid_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        source_code_next = source_code_reg;
        report_code_next = report_code_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_SOURCE_CODE: source_code_next = pwdata[7:0];
                REG_REPORT_CODE: report_code_next = pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SOURCE_CODE: prdata = {{(PDATA_W-8){1'b0}}, source_code_reg};
            REG_REPORT_CODE: prdata = {{(PDATA_W-8){1'b0}}, report_code_reg};
        endcase
    end

    // One restoring division step per channel
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            dtrial[c] = {rem_reg[c], dq_reg[c][SUM_W-1]};
            dbit[c]   = (dtrial[c] >= {1'b0, cnt_reg[c]});
            drem[c]   = dbit[c] ? COUNT_W'(dtrial[c] - {1'b0, cnt_reg[c]})
                                : COUNT_W'(dtrial[c]);
        end
    end

    // Write port and registered read port
    assign mem_wdata = {in_sample[2], in_sample[1], in_sample[0]};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wpos_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[scan_addr_reg[ADDR_W-1:0]];
        end
    end

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        wpos_next      = wpos_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next    = 1'b0;
        upd_next       = upd_reg;
        div_cnt_next   = div_cnt_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            sum_next[c]    = sum_reg[c];
            cnt_next[c]    = cnt_reg[c];
            recomp_next[c] = recomp_reg[c];
            min_next[c]    = min_reg[c];
            max_next[c]    = max_reg[c];
            ssum_next[c]   = ssum_reg[c];
            dq_next[c]     = dq_reg[c];
            rem_next[c]    = rem_reg[c];
        end
        // Drop the result once the sink takes it
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    upd_next       = in_pass;
                    scan_addr_next = '0;
                    for (int c = 0; c < NUM_CH; c++) begin
                        min_next[c]    = '1;
                        max_next[c]    = '0;
                        ssum_next[c]   = '0;
                        recomp_next[c] = 1'b0;
                    end
                    // Push the samples and advance the running sums
                    if (in_pass) begin
                        mem_we = 1'b1;
                        if (fill_reg < FILL_W'(WINDOW_LEN)) begin
                            fill_next = fill_reg + 1'b1;
                        end
                        wpos_next = (wpos_reg == ADDR_W'(WINDOW_LEN - 1)) ? '0
                                                                         : wpos_reg + 1'b1;
                        for (int c = 0; c < NUM_CH; c++) begin
                            if (cnt_reg[c] < COUNT_LIMIT) begin
                                sum_next[c] = sum_reg[c] + SUM_W'(in_sample[c]);
                                cnt_next[c] = cnt_reg[c] + 1'b1;
                            end else begin
                                recomp_next[c] = 1'b1;
                            end
                        end
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Issue reads over the filled slots
                rd_en = (scan_addr_reg < fill_reg);
                if (rd_en) begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                rd_vld_next = rd_en;
                // Fold returned data into min, max and window sum
                if (rd_vld_reg) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (rd_data_reg[c*SAMPLE_W +: SAMPLE_W] < min_reg[c]) begin
                            min_next[c] = rd_data_reg[c*SAMPLE_W +: SAMPLE_W];
                        end
                        if (rd_data_reg[c*SAMPLE_W +: SAMPLE_W] > max_reg[c]) begin
                            max_next[c] = rd_data_reg[c*SAMPLE_W +: SAMPLE_W];
                        end
                        ssum_next[c] = ssum_reg[c] + SUM_W'(rd_data_reg[c*SAMPLE_W +: SAMPLE_W]);
                    end
                end
                // Scan done: reload saturated channels and start the divider
                if (!rd_en && !rd_vld_reg) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (recomp_reg[c]) begin
                            sum_next[c] = ssum_reg[c];
                            cnt_next[c] = COUNT_W'(fill_reg);
                            dq_next[c]  = ssum_reg[c];
                        end else begin
                            dq_next[c]  = sum_reg[c];
                        end
                        rem_next[c] = '0;
                    end
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    rem_next[c] = drem[c];
                    dq_next[c]  = {dq_reg[c][SUM_W-2:0], dbit[c]};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    out_data_next = '0;
                    for (int c = 0; c < NUM_CH; c++) begin
                        out_data_next[(3*c)*SAMPLE_W +: SAMPLE_W] =
                            (cnt_reg[c] == '0) ? '0 : dq_reg[c][SAMPLE_W-1:0];
                        out_data_next[(3*c+1)*SAMPLE_W +: SAMPLE_W] =
                            (fill_reg == '0) ? '0 : min_reg[c];
                        out_data_next[(3*c+2)*SAMPLE_W +: SAMPLE_W] =
                            (fill_reg == '0) ? '0 : max_reg[c];
                    end
                    out_data_next[3*NUM_CH*SAMPLE_W +: FILL_OUT_W] = FILL_OUT_W'(fill_reg);
                    out_user_next = upd_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            wpos_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            source_code_reg <= '0;
            report_code_reg <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= '0;
                cnt_reg[c] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            wpos_reg        <= wpos_next;
            rd_vld_reg      <= rd_vld_next;
            m_tvalid_reg    <= m_tvalid_next;
            source_code_reg <= source_code_next;
            report_code_reg <= report_code_next;
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= sum_next[c];
                cnt_reg[c] <= cnt_next[c];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        upd_reg       <= upd_next;
        div_cnt_reg   <= div_cnt_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        for (int c = 0; c < NUM_CH; c++) begin
            recomp_reg[c] <= recomp_next[c];
            min_reg[c]    <= min_next[c];
            max_reg[c]    <= max_next[c];
            ssum_reg[c]   <= ssum_next[c];
            dq_reg[c]     <= dq_next[c];
            rem_reg[c]    <= rem_next[c];
        end
    end

endmodule
